// File: rtl/core/rse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, constants and GF(256) helpers for the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    // field and data widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ECC_LEN_W  = 5;
    localparam logic [8:0]  FIELD_POLY = 9'h11D;
    localparam logic [ECC_LEN_W-1:0] RESET_ECC_LEN = 5'd10;

    // register map index of the length register
    localparam logic REG_ECC_LENGTH = 1'b0;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_BUILD,
        ST_RUN
    } rse_state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic              clear;      // zero remainder and coefficient
        logic              build;      // one generator multiply step
        logic              enc;        // one data byte enters the division
        logic              last;       // that byte closes the block
        logic              shift_out;  // output row advances one byte
        logic [BYTE_W-1:0] mul_b;      // root while building, feedback otherwise
    } rse_cell_ctrl_t;

    // multiply by alpha (x) modulo the field polynomial
    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] v);
        gf_xtime = {v[BYTE_W-2:0], 1'b0} ^ (v[BYTE_W-1] ? FIELD_POLY[BYTE_W-1:0]
                                                        : {BYTE_W{1'b0}});
    endfunction

    // full GF(256) product, shift-and-add over the bits of b
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] acc;
        x   = a;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        gf_mul = acc;
    endfunction

endpackage

// File: rtl/core/rse_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_cell
// One tap of the encoder row: holds a remainder byte, a generator coefficient
// and an output byte, with a single shared GF(256) multiplier.
// ----------------------------------------------------------------------------
module rse_cell (
    input  logic                          aclk,
    input  rse_pkg::rse_cell_ctrl_t       ctrl,
    input  logic [rse_pkg::BYTE_W-1:0]    rem_in,     // remainder of the next cell
    input  logic [rse_pkg::BYTE_W-1:0]    coef_in,    // coefficient of the previous cell
    input  logic [rse_pkg::BYTE_W-1:0]    out_in,     // output byte of the next cell
    output logic [rse_pkg::BYTE_W-1:0]    rem_out,
    output logic [rse_pkg::BYTE_W-1:0]    coef_out,
    output logic [rse_pkg::BYTE_W-1:0]    out_out
);
    import rse_pkg::*;

    logic [BYTE_W-1:0] rem_reg,  rem_next;
    logic [BYTE_W-1:0] coef_reg, coef_next;
    logic [BYTE_W-1:0] out_reg,  out_next;
    logic [BYTE_W-1:0] mul_a;
    logic [BYTE_W-1:0] prod;
    logic [BYTE_W-1:0] rem_upd;

    // shared multiplier: neighbor coefficient times root while building,
    // own coefficient times feedback while encoding
    assign mul_a   = ctrl.build ? coef_in : coef_reg;
    assign prod    = gf_mul(mul_a, ctrl.mul_b);
    assign rem_upd = rem_in ^ prod;

    // next values
    always_comb begin
        rem_next  = rem_reg;
        coef_next = coef_reg;
        out_next  = out_reg;
        if (ctrl.clear) begin
            rem_next  = '0;
            coef_next = '0;
        end else if (ctrl.build) begin
            coef_next = coef_reg ^ prod;
        end else if (ctrl.enc) begin
            rem_next = ctrl.last ? '0 : rem_upd;
        end
        if (ctrl.enc && ctrl.last) begin
            out_next = rem_upd;
        end else if (ctrl.shift_out) begin
            out_next = out_in;
        end
    end

    // cell storage
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        coef_reg <= coef_next;
        out_reg  <= out_next;
    end

    assign rem_out  = rem_reg;
    assign coef_out = coef_reg;
    assign out_out  = out_reg;

endmodule

// File: rtl/core/reed_solomon_ecc_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reed_solomon_ecc_encoder_core
// Systematic Reed-Solomon encoder over GF(256), polynomial 0x11D, built as a
// row of identical cells with one multiplier each.
// ----------------------------------------------------------------------------
//  channel   direction  tdata / data           tlast / flag
//  s_axis    in         [7:0] data_byte        block_end
//  m_axis    out        [7:0] ecc_byte         run_last
//  apb       in/out     reg 0 ecc_length[4:0]  -
//
//  one data byte per cycle while s_axis_tready is high: every cell updates its remainder in parallel
//  correction bytes leave one per cycle while m_axis_tready is high, from cell 0 of the output row
//  after reset or a length write, the generator is rebuilt in the cell row: a clear
//  state, then build steps over the saturated length, with s_axis_tready low
//  a block-end byte waits until the previous block's correction bytes are
//  gone or the last of them is taken in the same cycle; other bytes are taken
//  regardless
//  reset is synchronous, active low
// ----------------------------------------------------------------------------
module reed_solomon_ecc_encoder_core #(
    parameter int unsigned MAX_ECC = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
    input  logic                          s_axis_tlast,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] ecc_byte
    output logic                          m_axis_tlast,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rse_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ECC + 1);

    rse_state_t             state_reg, state_next;
    logic [ECC_LEN_W-1:0]   len_reg,   len_next;
    logic [CNT_W-1:0]       build_cnt_reg, build_cnt_next;
    logic [CNT_W-1:0]       out_cnt_reg,   out_cnt_next;
    logic [BYTE_W-1:0]      root_reg,  root_next;
    logic [CNT_W-1:0]       eff_len;
    logic                   cfg_wr;
    logic                   in_acc;
    logic                   out_acc;
    logic                   out_free;
    logic [BYTE_W-1:0]      factor;
    rse_cell_ctrl_t         cell_ctrl;

    logic [BYTE_W-1:0] rem_link  [MAX_ECC+1];
    logic [BYTE_W-1:0] coef_link [MAX_ECC+1];
    logic [BYTE_W-1:0] out_link  [MAX_ECC+1];

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ECC_LENGTH);
    assign prdata = (paddr[2] == REG_ECC_LENGTH) ? {{(32-ECC_LEN_W){1'b0}}, len_reg}
                                                 : 32'd0;

    // effective length, saturated to 1 .. MAX_ECC
    always_comb begin
        if (len_reg == '0) begin
            eff_len = CNT_W'(1);
        end else if (int'(len_reg) > int'(MAX_ECC)) begin
            eff_len = CNT_W'(MAX_ECC);
        end else begin
            eff_len = CNT_W'(len_reg);
        end
    end

    // handshakes
    assign out_free      = (out_cnt_reg == '0) ||
                           ((out_cnt_reg == CNT_W'(1)) && m_axis_tready);
    assign s_axis_tready = (state_reg == ST_RUN) && (!s_axis_tlast || out_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (out_cnt_reg != '0);
    assign m_axis_tlast  = (out_cnt_reg == CNT_W'(1));
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = out_link[0];

    // feedback byte of the division
    assign factor = s_axis_tdata ^ rem_link[0];

    // sequencer next state and cell commands
    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        build_cnt_next = build_cnt_reg;
        root_next      = root_reg;
        cell_ctrl      = '0;
        case (state_reg)
            ST_CLEAR: begin
                cell_ctrl.clear = 1'b1;
                build_cnt_next  = eff_len;
                root_next       = 8'h01;
                state_next      = ST_BUILD;
            end
            ST_BUILD: begin
                cell_ctrl.build = 1'b1;
                cell_ctrl.mul_b = root_reg;
                root_next       = gf_xtime(root_reg);
                build_cnt_next  = build_cnt_reg - CNT_W'(1);
                if (build_cnt_reg == CNT_W'(1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cell_ctrl.enc   = in_acc;
                cell_ctrl.last  = s_axis_tlast;
                cell_ctrl.mul_b = factor;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        cell_ctrl.shift_out = out_acc;
        if (cfg_wr) begin
            len_next   = pwdata[ECC_LEN_W-1:0];
            state_next = ST_CLEAR;
        end
    end

    // output byte count
    always_comb begin
        out_cnt_next = out_cnt_reg;
        if (in_acc && s_axis_tlast) begin
            out_cnt_next = eff_len;
        end else if (out_acc) begin
            out_cnt_next = out_cnt_reg - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            len_reg       <= RESET_ECC_LEN;
            build_cnt_reg <= '0;
            out_cnt_reg   <= '0;
            root_reg      <= 8'h01;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            build_cnt_reg <= build_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            root_reg      <= root_next;
        end
    end

    // row ends
    assign rem_link[MAX_ECC] = '0;
    assign out_link[MAX_ECC] = '0;
    assign coef_link[0]      = 8'h01;

    // cell row
    for (genvar j = 0; j < MAX_ECC; j++) begin : g_cell
        rse_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .rem_in   (rem_link[j+1]),
            .coef_in  (coef_link[j]),
            .out_in   (out_link[j+1]),
            .rem_out  (rem_link[j]),
            .coef_out (coef_link[j+1]),
            .out_out  (out_link[j])
        );
    end

`ifndef SYNTHESIS
    // no byte is taken while the generator is being rebuilt
    a_no_accept_in_build: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_RUN) |-> !s_axis_tready)
        else $error("input accepted during generator rebuild");

    // a block end always produces correction bytes next cycle
    a_block_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_axis_tlast) |=> m_axis_tvalid)
        else $error("block end did not start correction output");

    // a non-final correction byte is always followed by another
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("correction run stopped before its last byte");

    // rebuild finishes after its count unless restarted
    a_build_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUILD && build_cnt_reg == CNT_W'(1) && !cfg_wr)
        |=> (state_reg == ST_RUN))
        else $error("generator rebuild did not finish");
`endif

endmodule

// File: tb/tb_reed_solomon_ecc_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reed_solomon_ecc_encoder_core
// Self-checking bench for the GF(256) Reed-Solomon parity encoder. Data bytes
// are streamed in blocks while a local division model computes the parity
// bytes each closing byte should release; every parity transaction is compared
// against the oldest predicted byte. Covers the default length, length writes
// including saturation, ignored register writes, partial blocks discarded by a
// length write, random blocks and a long output stall.
// ----------------------------------------------------------------------------
module tb_reed_solomon_ecc_encoder_core;

    import rse_pkg::*;

    localparam int unsigned MAX_PARITY = 30;
    localparam logic [2:0]  ADDR_ECC_LENGTH = {REG_ECC_LENGTH, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED   = 3'd4;
    localparam int          IDLE_PCT        = 8;
    localparam int          SETTLE_CYCLES   = 8;

    typedef struct {
        logic [7:0] ecc_byte;
        logic       run_last;
    } parity_word_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input stream
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;  // block_end

    // result stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] ecc_byte
    logic        m_axis_tlast;          // run_last

    // register port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // local model of the encoder
    logic [ECC_LEN_W-1:0] len_reg;
    int unsigned          parity_len;
    logic [7:0]           rem_bytes [MAX_PARITY];
    logic [7:0]           gen_poly  [MAX_PARITY+1];
    parity_word_t         pending_parity [$];

    // stimulus control and bookkeeping
    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int hold_left    = 0;
    int errors       = 0;
    int bytes_sent   = 0;
    int blocks_sent  = 0;
    int parity_seen  = 0;
    int len_writes   = 0;

    reed_solomon_ecc_encoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // field product, msb-first horner over the bits of a
    function automatic logic [7:0] gf256_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 7; i >= 0; i--) begin
            p = {p[6:0], 1'b0} ^ (p[7] ? FIELD_POLY[7:0] : 8'h00);
            if (a[i]) begin
                p = p ^ b;
            end
        end
        return p;
    endfunction

    // generator = prod (x + alpha^i), i = 0 .. n-1, lowest order first
    function automatic void rebuild_generator(input int unsigned n);
        logic [7:0] root;
        root = 8'h01;
        foreach (gen_poly[k]) gen_poly[k] = 8'h00;
        gen_poly[0] = 8'h01;
        for (int unsigned i = 0; i < n; i++) begin
            for (int unsigned j = i + 1; j > 0; j--) begin
                gen_poly[j] = gen_poly[j-1] ^ gf256_mul(gen_poly[j], root);
            end
            gen_poly[0] = gf256_mul(gen_poly[0], root);
            root        = gf256_mul(root, 8'h02);
        end
    endfunction

    // length register write: saturate, rebuild, drop any partial block
    function automatic void set_ecc_length(input logic [31:0] value);
        len_reg = value[ECC_LEN_W-1:0];
        if (len_reg == 0) begin
            parity_len = 1;
        end else if (len_reg > MAX_PARITY) begin
            parity_len = MAX_PARITY;
        end else begin
            parity_len = 32'(len_reg);
        end
        rebuild_generator(parity_len);
        foreach (rem_bytes[k]) rem_bytes[k] = 8'h00;
    endfunction

    // one division step; a closing byte releases the remainder
    function automatic void encode_byte(input logic [7:0] data, input logic block_end);
        logic [7:0]   factor;
        parity_word_t w;
        factor = data ^ rem_bytes[0];
        for (int unsigned j = 0; j + 1 < parity_len; j++) begin
            rem_bytes[j] = rem_bytes[j+1];
        end
        rem_bytes[parity_len-1] = 8'h00;
        for (int unsigned j = 0; j < parity_len; j++) begin
            rem_bytes[j] = rem_bytes[j] ^ gf256_mul(gen_poly[parity_len-1-j], factor);
        end
        if (block_end) begin
            for (int unsigned j = 0; j < parity_len; j++) begin
                w.ecc_byte = rem_bytes[j];
                w.run_last = (j + 1 == parity_len);
                pending_parity.push_back(w);
            end
            foreach (rem_bytes[k]) rem_bytes[k] = 8'h00;
        end
    endfunction

    // output ready: long hold when requested, else random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left     = hold_left - 1;
        end else if (sink_idle_en && $urandom_range(99) < IDLE_PCT) begin
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // compare every parity transaction with the oldest prediction
    always @(posedge aclk) begin
        parity_word_t exp_w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            parity_seen++;
            if (pending_parity.size() == 0) begin
                $display("%0t: unexpected parity byte %02h last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                exp_w = pending_parity.pop_front();
                if (m_axis_tdata !== exp_w.ecc_byte) begin
                    $display("%0t: ecc_byte expected %02h actual %02h",
                             $time, exp_w.ecc_byte, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== exp_w.run_last) begin
                    $display("%0t: run_last expected %0b actual %0b",
                             $time, exp_w.run_last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // offer one data byte and wait for its transaction
    task automatic send_byte(input logic [7:0] data, input logic block_end);
        @(negedge aclk);
        if (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        s_axis_tlast  = block_end;
        do @(posedge aclk); while (!s_axis_tready);
        encode_byte(data, block_end);
        bytes_sent++;
        if (block_end) begin
            blocks_sent++;
        end
    endtask

    // let all predicted parity arrive, then give the core time to settle
    task automatic drain;
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_parity.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // two-phase register write, only issued while the core is idle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        drain();
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_ECC_LENGTH) begin
            set_ecc_length(value);
            len_writes++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // block of random bytes, closing byte last
    task automatic send_block(input int n_bytes, input bit closed);
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(8'($urandom_range(0, 255)), closed && (i == n_bytes - 1));
        end
    endtask

    // blocks at the length left by reset
    task automatic test_reset_length;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        drain();
    endtask

    // one-byte blocks with extreme data
    task automatic test_single_byte_blocks;
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b1);
        drain();
    endtask

    // smallest and largest lengths, plus saturation of 0 and 31
    task automatic test_length_extremes;
        write_reg(ADDR_ECC_LENGTH, 32'd1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b1);
        write_reg(ADDR_ECC_LENGTH, 32'd30);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_reg(ADDR_ECC_LENGTH, 32'd0);
        send_byte(8'h37, 1'b1);
        write_reg(ADDR_ECC_LENGTH, 32'd31);
        send_byte(8'hC3, 1'b1);
        write_reg(ADDR_ECC_LENGTH, 32'hFFFF_FFE2);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        drain();
    endtask

    // a write to an unmapped address must leave the length alone
    task automatic test_unmapped_write;
        write_reg(ADDR_UNMAPPED, 32'd7);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        drain();
    endtask

    // a length write between bytes drops the partial block
    task automatic test_midblock_length_write;
        write_reg(ADDR_ECC_LENGTH, 32'd4);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        write_reg(ADDR_ECC_LENGTH, 32'd6);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b1);
        drain();
    endtask

    // random blocks across several lengths, one phase with no idling
    task automatic test_random_blocks;
        int target;
        int phase;
        int n;
        target = bytes_sent + 60;
        phase  = 0;
        while (bytes_sent < target) begin
            case (phase % 5)
                0: write_reg(ADDR_ECC_LENGTH, 32'd30);
                1: write_reg(ADDR_ECC_LENGTH, $urandom & 32'hFFFF_FFE0);
                2: write_reg(ADDR_ECC_LENGTH, $urandom);
                default: write_reg(ADDR_ECC_LENGTH,
                                   32'({$urandom, 5'($urandom_range(1, 30))}));
            endcase
            src_idle_en  = (phase != 2);
            sink_idle_en = (phase != 2);
            repeat ($urandom_range(2, 5)) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24)
                                                : $urandom_range(1, 6);
                send_block(n, 1'b1);
            end
            // sometimes leave a block open for the next length write to drop
            if ($urandom_range(0, 1) == 1) begin
                send_block($urandom_range(1, 3), 1'b0);
            end
            phase++;
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        drain();
    endtask

    // receiver holds off while short blocks keep coming
    task automatic test_output_stall;
        write_reg(ADDR_ECC_LENGTH, 32'd8);
        @(negedge aclk);
        hold_left = 300;
        repeat (12) send_block($urandom_range(1, 3), 1'b1);
        drain();
    endtask

    // watchdog
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        set_ecc_length(32'(RESET_ECC_LEN));
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_length();
        test_single_byte_blocks();
        test_length_extremes();
        test_unmapped_write();
        test_midblock_length_write();
        test_random_blocks();
        test_output_stall();

        drain();
        repeat (50) @(posedge aclk);
        $display("covered %0d data bytes in %0d blocks, %0d parity bytes checked",
                 bytes_sent, blocks_sent, parity_seen);
        $display("lengths 1..30 with saturation, %0d length writes, one 300-cycle stall",
                 len_writes);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
